// File: design/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and constants for the ordered list table engine.
// ----------------------------------------------------------------------------
package olt_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		K_APPEND  = 3'd0,
		K_INSERT  = 3'd1,
		K_EXTRACT = 3'd2,
		K_FIND    = 3'd3,
		K_DELETE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_APPEND = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [IDX_W-1:0]   pos;
		logic [CNT_W-1:0]   cnt;
		logic [DATA_W-1:0]  value;
	} cell_ctl_t;

endpackage

// File: design/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell
// One list slot: holds an element, takes from a neighbor on insert/remove,
// compares against the broadcast value.
// ----------------------------------------------------------------------------
module olt_cell (
	input  logic                       clk,
	input  logic [olt_pkg::IDX_W-1:0]  idx,
	input  olt_pkg::cell_ctl_t         ctl,
	input  logic [olt_pkg::DATA_W-1:0] from_left,
	input  logic [olt_pkg::DATA_W-1:0] from_right,
	output logic [olt_pkg::DATA_W-1:0] data,
	output logic [olt_pkg::DATA_W-1:0] sel_data,
	output logic                       match
);

	logic [olt_pkg::DATA_W-1:0] data_q;
	logic [olt_pkg::CNT_W-1:0]  idx_ext;

	assign idx_ext  = olt_pkg::CNT_W'(idx);
	assign data     = data_q;
	assign sel_data = (idx == ctl.pos) ? data_q : '0;
	assign match    = (idx_ext < ctl.cnt) && (data_q == ctl.value);

	always_ff @(posedge clk) begin
		case (ctl.op)
			olt_pkg::OP_APPEND: begin
				if (idx_ext == ctl.cnt) data_q <= ctl.value;
			end
			olt_pkg::OP_INSERT: begin
				if (idx > ctl.pos) data_q <= from_left;
				else if (idx == ctl.pos) data_q <= ctl.value;
			end
			olt_pkg::OP_REMOVE: begin
				if (idx >= ctl.pos) data_q <= from_right;
			end
			default: ;
		endcase
	end

endmodule

// File: design/ordered_list_table_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_table_engine_top
// Packed list of signed elements held in a row of shifting cells.
// Result strobe comes in the cycle after the transfer; a delete run of N > 0
// elements is done as single-place left shifts, one per cycle, and strobes
// after the last shift. One request per cycle for all other kinds; busy during a run.
// Reset: asynchronous, clears fill count, state and strobe; cell contents
// are undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 kind,
	input  logic [olt_pkg::IDX_W-1:0]  position,
	input  logic signed [31:0]         value,
	input  logic [5:0]                 run_length,
	output logic                       done,
	output logic [1:0]                 status,
	output logic signed [31:0]         data_out,
	output logic [olt_pkg::IDX_W-1:0]  found_at,
	output logic [olt_pkg::CNT_W-1:0]  fill
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	localparam int CAP = olt_pkg::CAPACITY;

	state_t                      state_q, state_d;
	logic [olt_pkg::CNT_W-1:0]   count_q, count_d;
	logic [olt_pkg::IDX_W-1:0]   pos_q;
	logic [5:0]                  left_q, left_d;

	logic                        done_q, done_d;
	olt_pkg::status_t            status_q, status_d;
	logic [31:0]                 data_q, data_d;
	logic [olt_pkg::IDX_W-1:0]   found_q, found_d;

	olt_pkg::cell_ctl_t          ctl;
	logic [olt_pkg::DATA_W-1:0]  cell_data [CAP];
	logic [olt_pkg::DATA_W-1:0]  cell_sel  [CAP];
	logic [CAP-1:0]              cell_match;
	logic [olt_pkg::DATA_W-1:0]  ext_data;
	logic [olt_pkg::IDX_W-1:0]   hit_idx;
	logic                        hit;
	logic                        accept;
	logic [olt_pkg::CNT_W-1:0]   pos_ext;
	logic [6:0]                  run_end;
	logic                        full;

	assign accept  = start && !busy;
	assign busy    = (state_q == S_RUN);
	assign pos_ext = olt_pkg::CNT_W'(position);
	assign run_end = 7'(position) + 7'(run_length);
	assign full    = (count_q >= olt_pkg::CNT_W'(CAP));

	genvar g;
	generate
		for (g = 0; g < CAP; g++) begin : g_cell
			olt_cell u_cell (
				.clk        (clk),
				.idx        (olt_pkg::IDX_W'(g)),
				.ctl        (ctl),
				.from_left  ((g == 0) ? '0 : cell_data[(g == 0) ? 0 : g - 1]),
				.from_right ((g == CAP - 1) ? '0 : cell_data[(g == CAP - 1) ? g : g + 1]),
				.data       (cell_data[g]),
				.sel_data   (cell_sel[g]),
				.match      (cell_match[g])
			);
		end
	endgenerate

	always_comb begin
		ext_data = '0;
		hit      = 1'b0;
		hit_idx  = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			ext_data = ext_data | cell_sel[i];
			if (cell_match[i]) begin
				hit     = 1'b1;
				hit_idx = olt_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		left_d    = left_q;
		done_d    = 1'b0;
		status_d  = olt_pkg::ST_OK;
		data_d    = '0;
		found_d   = '0;
		ctl.op    = olt_pkg::OP_NONE;
		ctl.pos   = position;
		ctl.cnt   = count_q;
		ctl.value = value;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					case (kind)
						olt_pkg::K_APPEND: begin
							if (full) begin
								status_d = olt_pkg::ST_FULL;
							end else begin
								ctl.op  = olt_pkg::OP_APPEND;
								count_d = count_q + olt_pkg::CNT_W'(1);
							end
						end
						olt_pkg::K_INSERT: begin
							if (pos_ext >= count_q) begin
								status_d = olt_pkg::ST_RANGE;
							end else if (full) begin
								status_d = olt_pkg::ST_FULL;
							end else begin
								ctl.op  = olt_pkg::OP_INSERT;
								count_d = count_q + olt_pkg::CNT_W'(1);
							end
						end
						olt_pkg::K_EXTRACT: begin
							if (pos_ext >= count_q) begin
								status_d = olt_pkg::ST_RANGE;
							end else begin
								ctl.op  = olt_pkg::OP_REMOVE;
								data_d  = ext_data;
								count_d = count_q - olt_pkg::CNT_W'(1);
							end
						end
						olt_pkg::K_FIND: begin
							if (hit) found_d = hit_idx;
							else status_d = olt_pkg::ST_MISSING;
						end
						olt_pkg::K_DELETE: begin
							if (run_end > 7'(count_q)) begin
								status_d = olt_pkg::ST_RANGE;
							end else if (run_length != '0) begin
								done_d  = 1'b0;
								ctl.op  = olt_pkg::OP_REMOVE;
								count_d = count_q - olt_pkg::CNT_W'(1);
								left_d  = run_length - 6'd1;
								if (run_length != 6'd1) state_d = S_RUN;
								else done_d = 1'b1;
							end
						end
						default: status_d = olt_pkg::ST_RANGE;
					endcase
				end
			end
			S_RUN: begin
				ctl.op  = olt_pkg::OP_REMOVE;
				ctl.pos = pos_q;
				count_d = count_q - olt_pkg::CNT_W'(1);
				left_d  = left_q - 6'd1;
				if (left_q == 6'd1) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		left_q   <= left_d;
		status_q <= status_d;
		data_q   <= data_d;
		found_q  <= found_d;
		if (accept) pos_q <= position;
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data_out = data_q;
	assign found_at = found_q;
	assign fill     = count_q;

endmodule

// File: tb/ordered_list_table_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_engine_checker
// Watches request transfers and result strobes of the list engine. It keeps
// its own copy of the list, predicts the reply to every accepted request and
// compares each strobed reply with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_checker
	import olt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [2:0]              kind,
	input  logic [IDX_W-1:0]        position,
	input  logic signed [31:0]      value,
	input  logic [5:0]              run_length,
	input  logic                    done,
	input  logic [1:0]              status,
	input  logic signed [31:0]      data_out,
	input  logic [IDX_W-1:0]        found_at,
	input  logic [CNT_W-1:0]        fill,
	output int                      errors,
	output int                      pending,
	output logic [CNT_W-1:0]        list_fill
);

	typedef struct packed {
		status_t                  st;
		logic signed [DATA_W-1:0] data;
		logic [IDX_W-1:0]         idx;
		logic [CNT_W-1:0]         cnt;
	} reply_t;

	logic signed [DATA_W-1:0] elems [CAPACITY];
	int                       used;
	reply_t                   replies [$];
	reply_t                   want;

	assign list_fill = used[CNT_W-1:0];

	function automatic reply_t apply_request(logic [2:0] k, logic [IDX_W-1:0] p,
			logic signed [31:0] v, logic [5:0] n);
		reply_t r;
		int     i;
		bit     hit;
		r = '{st: ST_OK, data: '0, idx: '0, cnt: '0};
		hit = 1'b0;
		case (k)
			K_APPEND: begin
				if (used >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					elems[used] = v;
					used++;
				end
			end
			K_INSERT: begin
				if (int'(p) >= used) begin
					r.st = ST_RANGE;
				end else if (used >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					for (i = used; i > int'(p); i--)
						elems[i] = elems[i-1];
					elems[p] = v;
					used++;
				end
			end
			K_EXTRACT: begin
				if (int'(p) >= used) begin
					r.st = ST_RANGE;
				end else begin
					r.data = elems[p];
					for (i = int'(p); i + 1 < used; i++)
						elems[i] = elems[i+1];
					used--;
				end
			end
			K_FIND: begin
				r.st = ST_MISSING;
				for (i = 0; i < used; i++) begin
					if (!hit && elems[i] == v) begin
						hit = 1'b1;
						r.st = ST_OK;
						r.idx = i[IDX_W-1:0];
					end
				end
			end
			K_DELETE: begin
				if (int'(p) + int'(n) > used) begin
					r.st = ST_RANGE;
				end else begin
					for (i = int'(p); i + int'(n) < used; i++)
						elems[i] = elems[i+int'(n)];
					used -= int'(n);
				end
			end
			default: begin
				r.st = ST_RANGE;
			end
		endcase
		r.cnt = used[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used = 0;
			replies.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (replies.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with no request outstanding: st=%0d data=%h idx=%0d fill=%0d",
							$realtime, status, data_out, found_at, fill);
				end else begin
					want = replies.pop_front();
					if (status !== want.st || data_out !== want.data ||
							found_at !== want.idx || fill !== want.cnt) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch exp st=%0d data=%h idx=%0d fill=%0d / got st=%0d data=%h idx=%0d fill=%0d",
								$realtime, want.st, want.data, want.idx, want.cnt,
								status, data_out, found_at, fill);
					end
				end
			end
			if (start && !busy)
				replies.push_back(apply_request(kind, position, value, run_length));
			pending = replies.size();
		end
	end

endmodule

// File: tb/ordered_list_table_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_engine_top_tb
// Drives directed and random list requests into the engine with random gaps,
// fills and drains the list repeatedly, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_top_tb;
	import olt_pkg::*;

	localparam int NUM_ITEMS = 1000;
	localparam int M_GROW    = 0;
	localparam int M_SHRINK  = 1;
	localparam int M_MIX     = 2;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [2:0]             kind;
	logic [IDX_W-1:0]       position;
	logic signed [31:0]     value;
	logic [5:0]             run_length;
	logic                   done;
	logic [1:0]             status;
	logic signed [31:0]     data_out;
	logic [IDX_W-1:0]       found_at;
	logic [CNT_W-1:0]       fill;

	int                     errors;
	int                     pending;
	logic [CNT_W-1:0]       list_fill;
	logic                   took;
	logic [31:0]            value_pool [8];

	ordered_list_table_engine_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.run_length (run_length),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.found_at   (found_at),
		.fill       (fill)
	);

	ordered_list_table_engine_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.run_length (run_length),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.found_at   (found_at),
		.fill       (fill),
		.errors     (errors),
		.pending    (pending),
		.list_fill  (list_fill)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// transfer flag of the last rising edge, read at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			took <= 1'b0;
		else
			took <= start && !busy;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 1))
			return value_pool[3'($urandom_range(0, 7))];
		return $urandom;
	endfunction

	task automatic issue(input logic [2:0] k, input int p, input logic [31:0] v, input int n);
		start = 1'b1;
		kind = k;
		position = p[IDX_W-1:0];
		value = v;
		run_length = n[5:0];
		do @(negedge clk); while (!took);
	endtask

	task automatic idle_gap(input int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// fill to capacity, hit the full cases, then clear with the longest run
	task automatic fill_probe();
		while (list_fill < CAPACITY)
			issue(K_APPEND, $urandom_range(0, 31), pick_value(), $urandom_range(0, 63));
		issue(K_APPEND, $urandom_range(0, 31), pick_value(), $urandom_range(0, 63));
		issue(K_INSERT, CAPACITY - 1, pick_value(), $urandom_range(0, 63));
		issue(K_INSERT, 0, pick_value(), $urandom_range(0, 63));
		issue(K_FIND, $urandom_range(0, 31), pick_value(), $urandom_range(0, 63));
		issue(K_EXTRACT, CAPACITY - 1, pick_value(), $urandom_range(0, 63));
		issue(K_APPEND, $urandom_range(0, 31), pick_value(), $urandom_range(0, 63));
		issue(K_DELETE, 0, pick_value(), CAPACITY);
	endtask

	task automatic random_request(input int mode);
		int         roll;
		int         f;
		int         p;
		int         n;
		int         room;
		logic [2:0] k;
		f = list_fill;
		p = $urandom_range(0, 31);
		n = $urandom_range(0, 63);
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			k = 3'($urandom_range(int'(K_DELETE) + 1, 7));
		end else begin
			roll = $urandom_range(0, 99);
			case (mode)
				M_GROW:
					k = roll < 40 ? K_APPEND : roll < 70 ? K_INSERT : roll < 85 ? K_FIND :
						roll < 93 ? K_EXTRACT : K_DELETE;
				M_SHRINK:
					k = roll < 10 ? K_APPEND : roll < 20 ? K_INSERT : roll < 35 ? K_FIND :
						roll < 75 ? K_EXTRACT : K_DELETE;
				default:
					k = roll < 25 ? K_APPEND : roll < 45 ? K_INSERT : roll < 70 ? K_FIND :
						roll < 90 ? K_EXTRACT : K_DELETE;
			endcase
			if (f > 0 && $urandom_range(0, 9) < 8)
				p = $urandom_range(0, f - 1);
			if (k == K_DELETE && p <= f && $urandom_range(0, 9) < 8) begin
				room = f - p;
				n = $urandom_range(0, room < 6 ? room : 6);
			end
		end
		issue(k, p, pick_value(), n);
	endtask

	initial begin
		int i;
		int mode;
		start = 1'b0;
		kind = K_APPEND;
		position = '0;
		value = '0;
		run_length = '0;
		arst_n = 1'b0;
		mode = M_MIX;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (i = 4; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list corner cases
		issue(K_FIND, 0, 32'h0, 0);
		issue(K_EXTRACT, 0, 32'h0, 0);
		issue(K_INSERT, 0, 32'h1, 0);
		issue(K_DELETE, 0, 32'h0, 0);
		issue(K_DELETE, 0, 32'h0, 1);
		// value extremes, insert at head and at last position
		issue(K_APPEND, 31, 32'h8000_0000, 63);
		issue(K_APPEND, 0, 32'h7FFF_FFFF, 0);
		issue(K_APPEND, 0, 32'h0000_0000, 0);
		issue(K_APPEND, 0, 32'hFFFF_FFFF, 0);
		issue(K_INSERT, 0, 32'h5, 0);
		issue(K_INSERT, 4, 32'h1234, 0);
		issue(K_FIND, 0, 32'h7FFF_FFFF, 0);
		issue(K_FIND, 0, 32'hFFFF_FFFF, 0);
		issue(K_FIND, 0, 32'h63, 0);
		issue(K_EXTRACT, 6, 32'h0, 0);
		issue(K_EXTRACT, 0, 32'h0, 0);
		issue(K_EXTRACT, 4, 32'h0, 0);
		issue(K_DELETE, 1, 32'h0, 2);
		issue(K_DELETE, 0, 32'h0, 63);
		issue(3'd5, 0, 32'h0, 0);
		issue(3'd6, 1, 32'h0, 1);
		issue(3'd7, 31, 32'hFFFF_FFFF, 63);
		issue(K_DELETE, 31, 32'h0, 0);
		issue(K_DELETE, 0, 32'h0, 2);

		fill_probe();
		for (i = 0; i < NUM_ITEMS; i++) begin
			if (i % 40 == 0)
				mode = $urandom_range(M_GROW, M_MIX);
			if (i == NUM_ITEMS / 2)
				fill_probe();
			if ((i < 300 || i >= 550) && $urandom_range(0, 99) < 10)
				idle_gap($urandom_range(1, 4));
			random_request(mode);
		end
		start = 1'b0;

		for (i = 0; i < 200 && pending != 0; i++)
			@(negedge clk);
		repeat (40) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
